>>> src/icc_pkg.sv
// Shared types and constants for the 2x2 image cross-correlation block.
// No dependencies; icc_cell, the top module and the bench import it.
package icc_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 8;
	localparam int COEF_BITS_DEF  = 8;

	// Row count limit and register geometry
	localparam int ROW_LIMIT    = 1024;
	localparam int ROW_BITS     = $clog2(ROW_LIMIT);
	localparam int DIM_BITS     = 11;
	localparam int REG_IDX_BITS = 3;

	localparam int WIDTH_RESET  = 3;
	localparam int HEIGHT_RESET = 3;

	// Window taps, in the order the cell chain consumes them
	localparam int TAPS      = 4;
	localparam int TAP_TL    = 0;
	localparam int TAP_TR    = 1;
	localparam int TAP_BL    = 2;
	localparam int TAP_BR    = 3;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_COEF_TL = 3'd0,
		REG_COEF_TR = 3'd1,
		REG_COEF_BL = 3'd2,
		REG_COEF_BR = 3'd3,
		REG_WIDTH   = 3'd4,
		REG_HEIGHT  = 3'd5
	} cfg_reg_t;

	// Control that travels with a window down the cell chain
	typedef struct packed {
		logic valid;
		logic last;
	} icc_ctl_t;

endpackage

>>> src/icc_ifs.sv
// Stream interfaces of the 2x2 cross-correlation block: pixel input, result output.
// Valid/ready handshake; depends on nothing else.
interface icc_pixel_if #(
	parameter int PIXEL_BITS = 8
);
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface icc_result_if #(
	parameter int RES_BITS = 18
);
	logic                       valid;
	logic                       ready;
	logic signed [RES_BITS-1:0] result;
	logic                       last;

	modport source (output valid, output result, output last, input ready);
	modport sink   (input valid, input result, input last, output ready);
endinterface

>>> src/icc_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read returns the old word when both ports hit the same address.
module icc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> src/icc_cell.sv
// One multiply-accumulate cell of the correlation chain.
// Depends on icc_pkg (control struct, tap count).
module icc_cell #(
	parameter int PIXEL_BITS = 8,
	parameter int COEF_BITS  = 8,
	parameter int RES_BITS   = 18,
	parameter int TAP        = 0
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          en,
	input  icc_pkg::icc_ctl_t                             ctl_in,
	input  logic [icc_pkg::TAPS-1:0][PIXEL_BITS-1:0]      win_in,
	input  logic signed [RES_BITS-1:0]                    sum_in,
	input  logic signed [COEF_BITS-1:0]                   coef,
	output icc_pkg::icc_ctl_t                             ctl_out,
	output logic [icc_pkg::TAPS-1:0][PIXEL_BITS-1:0]      win_out,
	output logic signed [RES_BITS-1:0]                    sum_out
);
	import icc_pkg::*;

	logic signed [PIXEL_BITS+COEF_BITS:0] prod;
	icc_ctl_t                             ctl_q;

	// pixel is unsigned: zero-extend before the signed multiply
	assign prod = $signed({1'b0, win_in[TAP]}) * coef;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			win_out <= win_in;
			sum_out <= sum_in + RES_BITS'(prod);
		end
	end

	assign ctl_out = ctl_q;
endmodule

>>> src/image_cross_correlation_2x2.sv
// 2x2 valid-mode cross-correlation over a raster pixel stream. One pixel is
// taken per clock unless the result side stalls. The pixel that completes a
// window is registered with the line-store read, then passes through four
// multiply-accumulate cells, the last of which is the output register. The
// rate is set by the line store (one write and one read per accepted pixel)
// and the cell chain (one window per cycle unless stalled). Pixels in row 0
// or column 0 produce no result. last marks the window whose bottom-right
// pixel is the final pixel of a frame. Registers: coefficient TL, TR, BL, BR
// (signed), image width, image height; width is clamped to [2, MAX_WIDTH] and
// height to [2, 1024]. Change them only while the block is idle. Coefficients
// reset to TL = 1, BR = -1, others 0; width and height reset to 3.
// Depends on icc_pkg, icc_ifs, icc_ram and icc_cell.
module image_cross_correlation_2x2 #(
	parameter int MAX_WIDTH  = icc_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = icc_pkg::PIXEL_BITS_DEF,
	parameter int COEF_BITS  = icc_pkg::COEF_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	icc_pixel_if.sink                                   pix,
	icc_result_if.source                                res,
	input  logic                                        wr_en,
	input  logic [icc_pkg::REG_IDX_BITS-1:0]            wr_index,
	input  logic [((COEF_BITS > icc_pkg::DIM_BITS) ? COEF_BITS
		: icc_pkg::DIM_BITS)-1:0]                       wr_data
);
	import icc_pkg::*;

	// Sum of four products of (PIXEL_BITS unsigned) x (COEF_BITS signed)
	localparam int RES_BITS = PIXEL_BITS + COEF_BITS + 2;
	localparam int CW       = $clog2(MAX_WIDTH);
	localparam int WW       = ((CW > DIM_BITS) ? CW : DIM_BITS) + 1;
	localparam int HW       = DIM_BITS + 1;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic signed [COEF_BITS-1:0] coef_q [TAPS];
	logic [DIM_BITS-1:0]         width_q;
	logic [DIM_BITS-1:0]         height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[TAP_TL] <= COEF_BITS'(1);
			coef_q[TAP_TR] <= '0;
			coef_q[TAP_BL] <= '0;
			coef_q[TAP_BR] <= '1;
			width_q        <= DIM_BITS'(WIDTH_RESET);
			height_q       <= DIM_BITS'(HEIGHT_RESET);
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_COEF_TL: coef_q[TAP_TL] <= wr_data[COEF_BITS-1:0];
				REG_COEF_TR: coef_q[TAP_TR] <= wr_data[COEF_BITS-1:0];
				REG_COEF_BL: coef_q[TAP_BL] <= wr_data[COEF_BITS-1:0];
				REG_COEF_BR: coef_q[TAP_BR] <= wr_data[COEF_BITS-1:0];
				REG_WIDTH:   width_q        <= wr_data[DIM_BITS-1:0];
				REG_HEIGHT:  height_q       <= wr_data[DIM_BITS-1:0];
				default: ; // unknown index: write dropped
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Flow control: whole pipeline moves when the output register is
	// free or being drained, so bubbles ride along with windows.
	// ---------------------------------------------------------------
	logic en;
	logic in_fire;

	assign en        = !res.valid || res.ready;
	assign pix.ready = en;
	assign in_fire   = pix.valid && en;

	// ---------------------------------------------------------------
	// Position counters (stage 0)
	// ---------------------------------------------------------------
	logic [CW-1:0]       col_q;
	logic [ROW_BITS-1:0] row_q;
	logic [WW-1:0]       width_ext, width_eff;
	logic [HW-1:0]       height_ext, height_eff;
	logic                col_end, row_end, emit;

	always_comb begin
		width_ext  = WW'(width_q);
		height_ext = HW'(height_q);
		priority if (width_ext < WW'(2)) begin
			width_eff = WW'(2);
		end else if (width_ext > WW'(MAX_WIDTH)) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = width_ext;
		end
		priority if (height_ext < HW'(2)) begin
			height_eff = HW'(2);
		end else if (height_ext > HW'(ROW_LIMIT)) begin
			height_eff = HW'(ROW_LIMIT);
		end else begin
			height_eff = height_ext;
		end
		// at-or-beyond compare so a shrunk geometry wraps on the next pixel
		col_end = WW'(col_q) >= (width_eff - WW'(1));
		row_end = HW'(row_q) >= (height_eff - HW'(1));
		emit    = (row_q != '0) && (col_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + ROW_BITS'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Line store: read the pixel above and overwrite it with the new
	// one in the same cycle (read-first), so it holds the row above.
	// ---------------------------------------------------------------
	logic [PIXEL_BITS-1:0] above;

	icc_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (in_fire),
		.waddr (col_q),
		.wdata (pix.pixel),
		.re    (in_fire),
		.raddr (col_q),
		.rdata (above)
	);

	// ---------------------------------------------------------------
	// Stage 1: window assembly. left_q tracks the previous pixel of the
	// row at accept time; ul_q takes the above pixel of each transfer as
	// it leaves stage 1, becoming the above-left pixel of the next one.
	// ---------------------------------------------------------------
	logic [PIXEL_BITS-1:0] left_q;
	logic [PIXEL_BITS-1:0] ul_q;
	logic                  v_s1;
	icc_ctl_t              ctl_s1;
	logic [PIXEL_BITS-1:0] px_s1;
	logic [PIXEL_BITS-1:0] left_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			ctl_s1 <= '0;
			left_q <= '0;
			ul_q   <= '0;
		end else begin
			if (en) begin
				v_s1         <= in_fire;
				ctl_s1.valid <= in_fire && emit;
				ctl_s1.last  <= row_end && col_end;
				if (v_s1) begin
					ul_q <= above;
				end
			end
			if (in_fire) begin
				left_q <= pix.pixel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1   <= pix.pixel;
			left_s1 <= left_q;
		end
	end

	// ---------------------------------------------------------------
	// Cell chain: each cell adds one product to the running sum and
	// passes the window on. The last cell's register is the output.
	// ---------------------------------------------------------------
	icc_ctl_t                              ctl [TAPS+1];
	logic signed [RES_BITS-1:0]            sum [TAPS+1];
	logic [TAPS-1:0][PIXEL_BITS-1:0]       win [TAPS];

	assign ctl[0]         = ctl_s1;
	assign sum[0]         = '0;
	assign win[0][TAP_TL] = ul_q;
	assign win[0][TAP_TR] = above;
	assign win[0][TAP_BL] = left_s1;
	assign win[0][TAP_BR] = px_s1;

	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		if (k == TAPS - 1) begin : g_tail
			icc_cell #(
				.PIXEL_BITS (PIXEL_BITS),
				.COEF_BITS  (COEF_BITS),
				.RES_BITS   (RES_BITS),
				.TAP        (k)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.ctl_in  (ctl[k]),
				.win_in  (win[k]),
				.sum_in  (sum[k]),
				.coef    (coef_q[k]),
				.ctl_out (ctl[k+1]),
				.win_out (),
				.sum_out (sum[k+1])
			);
		end else begin : g_body
			icc_cell #(
				.PIXEL_BITS (PIXEL_BITS),
				.COEF_BITS  (COEF_BITS),
				.RES_BITS   (RES_BITS),
				.TAP        (k)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.ctl_in  (ctl[k]),
				.win_in  (win[k]),
				.sum_in  (sum[k]),
				.coef    (coef_q[k]),
				.ctl_out (ctl[k+1]),
				.win_out (win[k+1]),
				.sum_out (sum[k+1])
			);
		end
	end

	assign res.valid  = ctl[TAPS].valid;
	assign res.last   = ctl[TAPS].last;
	assign res.result = sum[TAPS];
endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for image_cross_correlation_2x2: raster pixel transfers in,
// 2x2 window sums out, each compared with an in-bench prediction of the line-store window.
// Depends on icc_pkg, icc_ifs and the block itself.
module testbench;
	import icc_pkg::*;

	localparam int PIX_W   = PIXEL_BITS_DEF;
	localparam int COEF_W  = COEF_BITS_DEF;
	localparam int RES_W   = 18;
	localparam int DATA_W  = (COEF_BITS_DEF > DIM_BITS) ? COEF_BITS_DEF : DIM_BITS;

	// Margin for the block to answer after the pixel that closes a window.
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_LIMIT   = 4000;
	localparam int MAX_REPORTS   = 10;
	localparam int RANDOM_PIXELS = 300;

	// Register indexes past the last real register; writes there must be dropped.
	localparam logic [REG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [REG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

	typedef struct {
		logic signed [RES_W-1:0] value;
		logic                    last;
	} window_sum_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    wr_en;
	logic [REG_IDX_BITS-1:0] wr_index;
	logic [DATA_W-1:0]       wr_data;

	icc_pixel_if  #(.PIXEL_BITS(PIX_W)) pix_if ();
	icc_result_if #(.RES_BITS(RES_W))   res_if ();

	image_cross_correlation_2x2 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix_if),
		.res      (res_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Window predictor: its own copy of the registers, the previous row,
	// the two held pixels and the raster position.
	// ------------------------------------------------------------------
	logic [PIX_W-1:0]         prev_row [MAX_WIDTH_DEF];
	logic [PIX_W-1:0]         left_px;
	logic [PIX_W-1:0]         upleft_px;
	int unsigned              col_cnt;
	int unsigned              row_cnt;
	// Entries 0 .. row_fill-1 of the previous-row store hold real pixels.
	// Columns are visited from 0 upward, so the written part is always a prefix.
	int unsigned              row_fill;
	logic signed [COEF_W-1:0] kern [TAPS];
	logic [DIM_BITS-1:0]      width_reg;
	logic [DIM_BITS-1:0]      height_reg;

	window_sum_t sums_due [$];

	int unsigned errors;
	int unsigned pixels_sent;
	int unsigned stall_left;
	bit          steady;   // no gaps and no stalls while set

	function automatic int unsigned clamp_dim(logic [DIM_BITS-1:0] v, int unsigned hi);
		int unsigned d;
		d = int'(v);
		if (d < 2)
			return 2;
		if (d > hi)
			return hi;
		return d;
	endfunction

	function automatic int unsigned cur_width();
		return clamp_dim(width_reg, MAX_WIDTH_DEF);
	endfunction

	function automatic int unsigned cur_height();
		return clamp_dim(height_reg, ROW_LIMIT);
	endfunction

	function automatic void window_reset();
		kern[TAP_TL] = 8'sd1;
		kern[TAP_TR] = 8'sd0;
		kern[TAP_BL] = 8'sd0;
		kern[TAP_BR] = -8'sd1;
		width_reg  = DIM_BITS'(WIDTH_RESET);
		height_reg = DIM_BITS'(HEIGHT_RESET);
		left_px    = '0;
		upleft_px  = '0;
		col_cnt    = 0;
		row_cnt    = 0;
		row_fill   = 0;
	endfunction

	function automatic void window_reg_write(logic [REG_IDX_BITS-1:0] idx,
		logic [DATA_W-1:0] d);
		case (idx)
			REG_COEF_TL: kern[TAP_TL] = d[COEF_W-1:0];
			REG_COEF_TR: kern[TAP_TR] = d[COEF_W-1:0];
			REG_COEF_BL: kern[TAP_BL] = d[COEF_W-1:0];
			REG_COEF_BR: kern[TAP_BR] = d[COEF_W-1:0];
			REG_WIDTH:   width_reg    = d[DIM_BITS-1:0];
			REG_HEIGHT:  height_reg   = d[DIM_BITS-1:0];
			default: ;
		endcase
	endfunction

	// One accepted pixel: emit a sum if it closes a window, then shift the window.
	function automatic void window_take_pixel(logic [PIX_W-1:0] px);
		int unsigned      w;
		int unsigned      h;
		int unsigned      col;
		logic [PIX_W-1:0] above;
		int               acc;
		window_sum_t      s;
		w   = cur_width();
		h   = cur_height();
		col = (col_cnt >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : col_cnt;
		above = prev_row[col];
		if (row_cnt >= 1 && col >= 1) begin
			acc = int'(kern[TAP_TL]) * int'(upleft_px)
				+ int'(kern[TAP_TR]) * int'(above)
				+ int'(kern[TAP_BL]) * int'(left_px)
				+ int'(kern[TAP_BR]) * int'(px);
			s.value = acc[RES_W-1:0];
			s.last  = (row_cnt >= h - 1) && (col >= w - 1);
			sums_due.push_back(s);
		end
		upleft_px     = above;
		prev_row[col] = px;
		left_px       = px;
		if (col == row_fill)
			row_fill++;
		// A position at or past the last one wraps, also after a mid-frame shrink
		if (col >= w - 1) begin
			col_cnt = 0;
			row_cnt = (row_cnt >= h - 1) ? 0 : row_cnt + 1;
		end else begin
			col_cnt = col + 1;
		end
	endfunction

	// Pixels still needed to close the current frame; valid only while settled.
	function automatic int unsigned pixels_to_frame_end();
		int unsigned w;
		int unsigned h;
		int unsigned in_row;
		int unsigned rows;
		w      = cur_width();
		h      = cur_height();
		in_row = (col_cnt >= w - 1) ? 1 : w - col_cnt;
		rows   = (row_cnt >= h - 1) ? 0 : h - 1 - row_cnt;
		return in_row + rows * w;
	endfunction

	// Observe both transfers and register writes at the rising edge, pre-update values.
	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_en)
				window_reg_write(wr_index, wr_data);
			if (pix_if.valid && pix_if.ready)
				window_take_pixel(pix_if.pixel);
		end
	end

	function automatic void flag(string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t ns  mismatch: %s", $time, msg);
	endfunction

	// Result transfers against the oldest predicted window sum
	always @(posedge clk) begin : check_sums
		window_sum_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (sums_due.size() == 0) begin
				flag($sformatf("unexpected result %0d last %0b", res_if.result, res_if.last));
			end else begin
				want = sums_due.pop_front();
				if (res_if.result !== want.value || res_if.last !== want.last)
					flag($sformatf("result exp %0d got %0d, last exp %0b got %0b",
						want.value, res_if.result, want.last, res_if.last));
			end
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	// Result side back-pressure
	always @(negedge clk) begin
		if (steady) begin
			res_if.ready = 1'b1;
			stall_left   = 0;
		end else if (stall_left > 0) begin
			res_if.ready = 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 99) < 25) begin
			res_if.ready = 1'b0;
			stall_left   = draw_gap() - 1;
		end else begin
			res_if.ready = 1'b1;
		end
	end

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// One pixel transfer; valid is left high so back-to-back pixels have no bubble.
	task automatic send_pixel(input logic [PIX_W-1:0] px);
		int unsigned gap;
		gap = (steady || $urandom_range(0, 99) < 65) ? 0 : draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			pix_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_if.valid = 1'b1;
		pix_if.pixel = px;
		@(posedge clk);
		while (!pix_if.ready)
			@(posedge clk);
		pixels_sent++;
	endtask

	// Drop valid, let every predicted sum come out, then give the pipe time to empty.
	task automatic settle();
		int unsigned waited;
		waited = 0;
		@(negedge clk);
		pix_if.valid = 1'b0;
		while (sums_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [DATA_W-1:0] d);
		@(negedge clk);
		wr_en    = 1'b1;
		wr_index = idx;
		wr_data  = d;
		@(negedge clk);
		wr_en    = 1'b0;
	endtask

	task automatic set_frame(input int w, input int h);
		write_reg(REG_WIDTH, DATA_W'(w));
		write_reg(REG_HEIGHT, DATA_W'(h));
	endtask

	// Negative weights land in the 11-bit data word with the upper bits set,
	// which also checks that only the low coefficient bits are kept.
	task automatic set_kernel(input int tl, input int tr, input int bl, input int br);
		write_reg(REG_COEF_TL, DATA_W'(tl));
		write_reg(REG_COEF_TR, DATA_W'(tr));
		write_reg(REG_COEF_BL, DATA_W'(bl));
		write_reg(REG_COEF_BR, DATA_W'(br));
	endtask

	// A whole frame from the frame start; fill < 0 means random pixels.
	task automatic send_frame(input int fill);
		int unsigned n;
		n = cur_width() * cur_height();
		repeat (n)
			send_pixel((fill < 0) ? rand_pixel() : PIX_W'(fill));
	endtask

	// Close a frame that was left mid-way; call only when settled.
	task automatic finish_frame();
		int unsigned n;
		n = pixels_to_frame_end();
		repeat (n)
			send_pixel(rand_pixel());
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset weights (TL = 1, BR = -1) on the reset 3x3 frame, then a second
	// frame to see the position counters wrap and last come round again.
	task automatic test_reset_defaults();
		int i;
		for (i = 0; i < 9; i++)
			send_pixel((i % 3 == 0) ? 8'hFF : 8'h00);
		send_frame(-1);
	endtask

	// Largest negative and positive sums, and a mixed-sign kernel
	task automatic test_kernel_extremes();
		settle();
		set_frame(2, 2);
		set_kernel(-128, -128, -128, -128);
		send_frame(255);
		settle();
		set_kernel(127, 127, 127, 127);
		send_frame(255);
		settle();
		set_kernel(127, -128, -128, 127);
		send_frame(-1);
	endtask

	// Width and height below 2 act as 2; writes to unused indexes are dropped
	task automatic test_geometry_clamps();
		settle();
		set_frame(0, 1);
		send_frame(-1);
		settle();
		set_frame(1, 0);
		send_frame(-1);
		settle();
		write_reg(REG_SPARE_LO, '1);
		write_reg(REG_SPARE_HI, DATA_W'(7));
		send_frame(-1);
	endtask

	// Geometry rewritten mid-frame: counters are kept and wrap on the next pixel
	// when they sit at or past the new last position.
	task automatic test_midframe_geometry();
		settle();
		set_frame(6, 4);
		repeat (15) send_pixel(rand_pixel());   // row 2, column 3
		settle();
		write_reg(REG_WIDTH, DATA_W'(3));       // column now past the end
		finish_frame();

		settle();
		set_frame(6, 5);
		repeat (20) send_pixel(rand_pixel());   // row 3, column 2
		settle();
		write_reg(REG_HEIGHT, DATA_W'(2));      // row now past the end
		finish_frame();

		// Widen mid-frame only as far as the previous row holds real pixels
		settle();
		set_frame(3, 4);
		repeat (4) send_pixel(rand_pixel());
		settle();
		write_reg(REG_WIDTH, DATA_W'(6));
		finish_frame();
	endtask

	function automatic int rand_dim(int hi_common, int hi_rare);
		case ($urandom_range(0, 19))
			0: return 0;
			1: return 1;
			2, 3: return $urandom_range(hi_common + 1, hi_rare);
			default: return $urandom_range(2, hi_common);
		endcase
	endfunction

	// Mostly complete small frames with random content and settings, some
	// frames with their geometry rewritten part-way through.
	task automatic test_random_frames();
		int unsigned goal;
		int unsigned n;
		int unsigned cap;
		goal = pixels_sent + RANDOM_PIXELS;
		while (pixels_sent < goal) begin
			steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 2) == 0) begin
				settle();
				write_reg(REG_COEF_TL, DATA_W'($urandom_range(0, 2047)));
				write_reg(REG_COEF_TR, DATA_W'($urandom_range(0, 2047)));
				write_reg(REG_COEF_BL, DATA_W'($urandom_range(0, 2047)));
				write_reg(REG_COEF_BR, DATA_W'($urandom_range(0, 2047)));
				set_frame(rand_dim(8, 40), rand_dim(5, 12));
			end
			if ($urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, cur_width() * cur_height() - 1);
				repeat (n)
					send_pixel(rand_pixel());
				settle();
				if ($urandom_range(0, 1) == 0) begin
					cap = (row_fill < 10) ? row_fill : 10;
					write_reg(REG_WIDTH, DATA_W'($urandom_range(0, cap)));
				end else begin
					write_reg(REG_HEIGHT, DATA_W'($urandom_range(0, 7)));
				end
				finish_frame();
			end else begin
				send_frame(-1);
			end
		end
		steady = 0;
	endtask

	// Register values above the limits, then shrunk mid-frame so each frame
	// closes after a few rows
	task automatic test_frame_extremes();
		settle();
		set_kernel($urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 255));
		set_frame(2047, 2047);
		repeat (40) send_pixel(rand_pixel());   // row 0, column 40
		settle();
		set_frame(8, 3);                        // column now past the end
		finish_frame();

		settle();
		set_frame(2, 1024);
		repeat (30) send_pixel(rand_pixel());   // row 15, column 0
		settle();
		write_reg(REG_HEIGHT, DATA_W'(0));      // row now past the end
		finish_frame();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		pix_if.valid = 1'b0;
		pix_if.pixel = '0;
		res_if.ready = 1'b0;
		wr_en        = 1'b0;
		wr_index     = REG_COEF_TL;
		wr_data      = '0;
		errors       = 0;
		pixels_sent  = 0;
		stall_left   = 0;
		steady       = 0;
		window_reset();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_kernel_extremes();
		test_geometry_clamps();
		test_midframe_geometry();
		test_random_frames();
		test_frame_extremes();

		settle();
		if (sums_due.size() != 0)
			flag($sformatf("%0d predicted results never arrived", sums_due.size()));
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Far beyond the slowest legal run: every pixel behind a long gap and a long stall
	initial begin
		#30_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
